FILE: rtl/assert_macros.svh
// assertion helpers for the automaton block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/nfa_pkg.sv
package nfa_pkg;
  localparam int NUM_STATES_DEF = 16;
  localparam int SYMBOL_BITS_DEF = 8;
  localparam int MAX_HW_STATES = 16;
  localparam int STATE_BITS = 4;
  localparam int SYM_W = 8;

  localparam logic [1:0] OP_WR_TRANS = 2'd0;
  localparam logic [1:0] OP_WR_EPS = 2'd1;
  localparam logic [1:0] OP_BEGIN = 2'd2;
  localparam logic [1:0] OP_SYMBOL = 2'd3;

  localparam logic CFG_INITIAL_STATE = 1'b0;
  localparam logic CFG_ACCEPT_MASK = 1'b1;

  // control record for the chain of cells; no cell in the project takes it
  typedef struct packed {
    logic load;   // clear accumulator at start of a pass
    logic take;   // cell contributes this cycle
  } nfa_ctl_t;
endpackage

FILE: rtl/nfa_symbol_matcher.sv
// channel | signals                                          | dir
// input   | valid, stall, op, source_state, in_symbol, successor_mask | in
// output  | out_valid, out_stall, accepted, active_states    | out
// config  | cfg_we, cfg_index, cfg_data                      | in
// load items write their row when taken; begin runs up to NUM_STATES closure rounds, then the done state
// symbol items walk the transition memory (one memory read per state), then run
// up to NUM_STATES closure rounds over the cell row, then the done state
// after reset a clearing pass zeroes all NS << SYMBOL_BITS words of the
// transition memory; no item is taken meanwhile
// a pending result in the output register stalls only the next begin or symbol
module nfa_symbol_matcher import nfa_pkg::*; #(
  parameter int NUM_STATES = NUM_STATES_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  output logic                  stall,
  input  logic [1:0]            op,
  input  logic [STATE_BITS-1:0] source_state,
  input  logic [SYM_W-1:0]      in_symbol,
  input  logic [15:0]           successor_mask,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  accepted,
  output logic [15:0]           active_states,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data
);
  `include "assert_macros.svh"

  localparam int NS = (NUM_STATES < MAX_HW_STATES) ? NUM_STATES : MAX_HW_STATES;
  localparam int SB = (NS > 1) ? $clog2(NS) : 1;
  localparam int AW = SB + SYMBOL_BITS;
  localparam int DEPTH = NS << SYMBOL_BITS;
  localparam int CW = $clog2(NS + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOVE  = 3'd2;
  localparam logic [2:0] ST_CLOS  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state, state_next;
  logic [AW-1:0] clr_addr;
  logic [STATE_BITS-1:0] init_reg;
  logic [NS-1:0] accept_reg;
  logic [NS-1:0] set, dest;
  logic [SYMBOL_BITS-1:0] sym;
  logic [CW-1:0] cnt;
  logic [CW-1:0] rounds;
  logic rd_vld;
  logic [15:0] tmem [DEPTH];
  logic [NS-1:0] rd_data;
  logic [NS-1:0] eps_valid;
  logic [NS-1:0] chain [NS+1];
  logic [NS-1:0] succ_l;

  logic in_acc;
  logic src_ok;
  logic [AW-1:0] wr_addr, rd_addr;
  logic mem_we;
  logic is_load;

  assign succ_l = successor_mask[NS-1:0];
  assign src_ok = ({{(32-STATE_BITS){1'b0}}, source_state} < NS);
  assign is_load = (op == OP_WR_TRANS) || (op == OP_WR_EPS);
  assign stall = (state != ST_IDLE) || (!is_load && out_valid);
  assign in_acc = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_reg <= '0;
      accept_reg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL_STATE: init_reg <= cfg_data[STATE_BITS-1:0];
        CFG_ACCEPT_MASK:   accept_reg <= cfg_data[NS-1:0];
        default: ;
      endcase
    end
  end

  // transition memory: one write port shared by clearing and loading
  assign mem_we = (state == ST_CLEAR) ||
                  (in_acc && op == OP_WR_TRANS && src_ok);
  assign wr_addr = (state == ST_CLEAR) ? clr_addr
                 : {source_state[SB-1:0], in_symbol[SYMBOL_BITS-1:0]};
  assign rd_addr = {cnt[SB-1:0], sym};

  always_ff @(posedge clk) begin
    if (mem_we) tmem[wr_addr] <= (state == ST_CLEAR) ? 16'd0 : 16'(succ_l);
    rd_data <= tmem[rd_addr][NS-1:0];
  end

  // epsilon row cells in a chain; valid bits give reset-zero rows
  logic [NS-1:0] eps_we;
  always_comb begin
    eps_we = '0;
    if (in_acc && op == OP_WR_EPS && src_ok) eps_we[source_state[SB-1:0]] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) eps_valid <= '0;
    else eps_valid <= eps_valid | eps_we;
  end

  assign chain[0] = set;
  for (genvar g = 0; g < NS; g++) begin : g_cell
    nfa_cell #(.NS(NS), .IDX(g)) u_cell (
      .clk(clk), .eps_we(eps_we[g]), .eps_wdata(succ_l),
      .set_in(set & eps_valid), .acc_in(chain[g]), .acc_out(chain[g+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_acc && op == OP_BEGIN) state_next = ST_CLOS;
                else if (in_acc && op == OP_SYMBOL) state_next = ST_MOVE;
      ST_MOVE:  if (cnt == CW'(NS)) state_next = ST_CLOS;
      ST_CLOS:  if (chain[NS] == set || rounds == CW'(NS - 1)) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      set <= '0;
      out_valid <= 1'b0;
      cnt <= '0;
      rounds <= '0;
      rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          rounds <= '0;
          rd_vld <= 1'b0;
          if (in_acc && op == OP_BEGIN) begin
            set <= ({{(32-STATE_BITS){1'b0}}, init_reg} < NS)
                   ? (NS'(1) << init_reg[SB-1:0]) : '0;
          end
          if (in_acc && op == OP_SYMBOL) begin
            sym <= in_symbol[SYMBOL_BITS-1:0];
            dest <= '0;
          end
        end
        ST_MOVE: begin
          // issue one read per state, collect the registered data in the following cycle
          rd_vld <= (cnt < CW'(NS)) && set[cnt[SB-1:0]];
          if (cnt < CW'(NS)) cnt <= cnt + 1'b1;
          if (rd_vld) dest <= dest | rd_data;
          if (state_next == ST_CLOS) set <= rd_vld ? (dest | rd_data) : dest;
        end
        ST_CLOS: begin
          set <= chain[NS];
          rounds <= rounds + 1'b1;
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          accepted <= |(set & accept_reg);
          active_states <= 16'(set);
        end
        default: ;
      endcase
    end
  end

  `CHK_NEXT(a_done_shows, state == ST_DONE, out_valid, "result not shown after closure")
  `CHK_ALWAYS(a_no_take_busy, !(in_acc && state != ST_IDLE), "item taken while busy")
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(active_states), "result lost")
endmodule

FILE: rtl/nfa_cell.sv
// one cell per state: holds its epsilon row and ors it into the passing set when its state is in the set
module nfa_cell import nfa_pkg::*; #(
  parameter int NS = NUM_STATES_DEF,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          eps_we,
  input  logic [NS-1:0] eps_wdata,
  input  logic [NS-1:0] set_in,
  input  logic [NS-1:0] acc_in,
  output logic [NS-1:0] acc_out
);
  logic [NS-1:0] eps_row;

  always_ff @(posedge clk) begin
    if (eps_we) eps_row <= eps_wdata;
  end

  // combinational or of this state's row into the running accumulation
  always_comb begin
    acc_out = acc_in;
    if (set_in[IDX]) acc_out = acc_in | eps_row;
  end
endmodule
